/* rtl/pplru_pkg.sv */
// ---------------------------------------------------------------------------
// pplru_pkg
// Shared types, constants and codes for the preserve-partitioned LRU block.
// ---------------------------------------------------------------------------
package pplru_pkg;

    localparam int NUM_WAYS = 16;
    localparam int NUM_SETS = 1024;

    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int TREE_N = 2 ** WAY_W;
    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int CNT_W  = $clog2(NUM_WAYS + 1);
    localparam int AGE_W  = 8;

    // operation codes
    localparam logic [2:0] OP_INVALIDATE = 3'd0;
    localparam logic [2:0] OP_HIT        = 3'd1;
    localparam logic [2:0] OP_FILL       = 3'd2;
    localparam logic [2:0] OP_QUERY      = 3'd3;
    localparam logic [2:0] OP_FLUSH      = 3'd4;

    // register indexes (byte address 4*i)
    localparam logic REG_MAX_AGE = 1'b0;
    localparam logic REG_QUOTA   = 1'b1;

    localparam logic [7:0] MAX_AGE_RST = 8'd15;
    localparam logic [4:0] QUOTA_RST   = 5'd4;

    typedef struct packed {
        logic [2:0] opcode;
        logic [9:0] set_index;
        logic [3:0] way_index;
        logic       preserve_request;
    } req_t;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       victim_preserved;
        logic [4:0] preserved_count;
    } rsp_t;

    typedef struct packed {
        logic [7:0] max_age;
        logic [4:0] preserve_quota;
    } cfg_t;

    // one memory row holds the whole set
    typedef struct packed {
        logic [NUM_WAYS-1:0][AGE_W-1:0] age;
        logic [NUM_WAYS-1:0]            pres;
        logic [NUM_WAYS-1:0]            used;
    } row_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

/* rtl/preserve_partitioned_lru_replacement.sv */
// ---------------------------------------------------------------------------
// preserve_partitioned_lru_replacement
// Per-set age / preserve / used state for a set-associative cache, kept one
// row per set in a synchronous memory and updated by read-modify-write.
// ---------------------------------------------------------------------------
// timing: the accepting edge registers the request and reads the set row;
//   done and result are then registered together from the execute state
// issue: busy is high in execute, so a new transaction is accepted only
//   after the previous row write-back through the single set memory
// reset: a clearing pass writes zero to all NUM_SETS rows;
//   busy stays high meanwhile, register writes are taken at any time
// results are a one-cycle strobe; the receiver cannot stall
module preserve_partitioned_lru_replacement
    import pplru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    output logic        done,
    output rsp_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t           state_reg;
    state_t           state_next;
    logic [SET_W-1:0] clr_reg;
    logic [SET_W-1:0] clr_next;
    req_t             req_reg;
    rsp_t             rsp_reg;
    logic             done_reg;
    logic             accept;
    cfg_t             cfg;

    logic             mem_wr;
    logic [SET_W-1:0] mem_waddr;
    row_t             mem_wdata;
    row_t             row;
    logic             upd_wr;
    row_t             upd_row;
    rsp_t             upd_rsp;

    assign accept = start && !busy;

    pplru_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pplru_set_ram u_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (SET_W'(req.set_index)),
        .rd_data (row),
        .wr_en   (mem_wr),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata)
    );

    pplru_update u_upd (
        .req    (req_reg),
        .row    (row),
        .cfg    (cfg),
        .wr_en  (upd_wr),
        .wr_row (upd_row),
        .rsp    (upd_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == NUM_SETS - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy      = 1'b1;
        mem_wr    = 1'b0;
        mem_waddr = SET_W'(req_reg.set_index);
        mem_wdata = upd_row;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_wr    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_EXEC:
            begin
                mem_wr = upd_wr;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= (state_reg == ST_EXEC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (state_reg == ST_EXEC)
        begin
            rsp_reg <= upd_rsp;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC))
        else $error("done without an executed transaction");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted transaction did not enter execute");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> busy && !done)
        else $error("transaction activity during clearing pass");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |-> (state_reg == ST_CLEAR || state_reg == ST_EXEC))
        else $error("set memory written outside clear or execute");

endmodule

/* rtl/pplru_set_ram.sv */
// ---------------------------------------------------------------------------
// pplru_set_ram
// Set-state memory: one row per set, one write port, registered read port.
// ---------------------------------------------------------------------------
module pplru_set_ram
    import pplru_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [SET_W-1:0] rd_addr,
    output row_t             rd_data,
    input  logic             wr_en,
    input  logic [SET_W-1:0] wr_addr,
    input  row_t             wr_data
);

    row_t mem [NUM_SETS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/pplru_update.sv */
// ---------------------------------------------------------------------------
// pplru_update
// Read-modify-write logic for one set row: new ages and bits, victim choice
// and preserved count.
// ---------------------------------------------------------------------------
module pplru_update
    import pplru_pkg::*;
(
    input  req_t req,
    input  row_t row,
    input  cfg_t cfg,
    output logic wr_en,
    output row_t wr_row,
    output rsp_t rsp
);

    // oldest member of a class, lowest way on ties (min tree over ways)
    function automatic logic [WAY_W-1:0] oldest(
        input logic [NUM_WAYS-1:0]            member,
        input logic [NUM_WAYS-1:0][AGE_W-1:0] age
    );
        logic [TREE_N-1:0][AGE_W:0]   k;
        logic [TREE_N-1:0][WAY_W-1:0] ix;
        for (int i = 0; i < TREE_N; i++)
        begin
            if (i < NUM_WAYS)
            begin
                k[i] = {~member[i], age[i]};
            end
            else
            begin
                k[i] = '1;
            end
            ix[i] = WAY_W'(i);
        end
        for (int lvl = 0; lvl < WAY_W; lvl++)
        begin
            for (int i = 0; i < (TREE_N >> (lvl + 1)); i++)
            begin
                if (k[2*i+1] < k[2*i])
                begin
                    k[i]  = k[2*i+1];
                    ix[i] = ix[2*i+1];
                end
                else
                begin
                    k[i]  = k[2*i];
                    ix[i] = ix[2*i];
                end
            end
        end
        return ix[0];
    endfunction

    logic             legal;
    logic             way_ok;
    logic [WAY_W-1:0] widx;
    logic [CNT_W-1:0] n_pres;
    logic [4:0]       count_sat;
    logic             any_zero;
    logic [WAY_W-1:0] zero_way;
    logic [WAY_W-1:0] v_pres;
    logic [WAY_W-1:0] v_plain;
    logic [WAY_W-1:0] victim;

    assign legal  = (req.opcode <= OP_FLUSH) && (32'(req.set_index) < NUM_SETS);
    assign way_ok = 32'(req.way_index) < NUM_WAYS;
    assign widx   = WAY_W'(req.way_index);

    always_comb
    begin
        n_pres = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            n_pres = n_pres + CNT_W'(row.pres[i]);
        end
    end

    assign count_sat = (32'(n_pres) > 31) ? 5'd31 : 5'(n_pres);

    // first free way
    always_comb
    begin
        any_zero = 1'b0;
        zero_way = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--)
        begin
            if (row.age[i] == '0)
            begin
                any_zero = 1'b1;
                zero_way = WAY_W'(i);
            end
        end
    end

    assign v_pres  = oldest(row.pres, row.age);
    assign v_plain = oldest(~row.pres, row.age);

    always_comb
    begin
        priority if (any_zero)
        begin
            victim = zero_way;
        end
        else if (32'(n_pres) > 32'(cfg.preserve_quota))
        begin
            victim = v_pres;
        end
        else if (32'(n_pres) == NUM_WAYS)
        begin
            victim = '0;
        end
        else
        begin
            victim = v_plain;
        end
    end

    always_comb
    begin
        wr_row = row;
        wr_en  = 1'b0;
        rsp    = '0;
        if (legal)
        begin
            unique case (req.opcode)
                OP_INVALIDATE:
                begin
                    if (way_ok)
                    begin
                        wr_en             = 1'b1;
                        wr_row.age[widx]  = '0;
                    end
                end
                OP_HIT:
                begin
                    if (way_ok)
                    begin
                        wr_en             = 1'b1;
                        wr_row.age[widx]  = cfg.max_age;
                        wr_row.used[widx] = 1'b1;
                    end
                end
                OP_FILL:
                begin
                    if (way_ok)
                    begin
                        wr_en             = 1'b1;
                        wr_row.pres[widx] = req.preserve_request;
                        wr_row.used[widx] = 1'b0;
                        // age the rest of the class
                        for (int i = 0; i < NUM_WAYS; i++)
                        begin
                            if (wr_row.pres[i] == req.preserve_request &&
                                wr_row.age[i] > 8'd1)
                            begin
                                wr_row.age[i] = wr_row.age[i] - 8'd1;
                            end
                        end
                        wr_row.age[widx] = cfg.max_age;
                    end
                end
                OP_QUERY:
                begin
                    rsp.victim_way       = 4'(victim);
                    rsp.victim_preserved = row.pres[victim];
                    rsp.preserved_count  = count_sat;
                end
                OP_FLUSH:
                begin
                    wr_en               = 1'b1;
                    wr_row.pres         = row.pres & row.used;
                    wr_row.used         = '0;
                    rsp.preserved_count = count_sat;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

endmodule

/* rtl/pplru_cfg.sv */
// ---------------------------------------------------------------------------
// pplru_cfg
// APB register file: max_age and preserve_quota.
// ---------------------------------------------------------------------------
module pplru_cfg
    import pplru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (paddr[2])
                REG_MAX_AGE: cfg_next.max_age        = pwdata[7:0];
                REG_QUOTA:   cfg_next.preserve_quota = pwdata[4:0];
                default:     cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_age        <= MAX_AGE_RST;
            cfg_reg.preserve_quota <= QUOTA_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MAX_AGE: prdata = {24'd0, cfg_reg.max_age};
            REG_QUOTA:   prdata = {27'd0, cfg_reg.preserve_quota};
            default:     prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
